// ===== rtl/fbcq_pkg.sv =====
`timescale 1ns / 1ps

package fbcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_WORDS_DEF   = 17;

    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic OP_WORD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] word;
        logic        end_of_command;
    } fbcq_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word_out;
        logic        word_is_final;
        logic [1:0]  status;
        logic [1:0]  applied_count;
        logic [31:0] frame_number;
        logic [4:0]  peak_occupancy;
        logic [31:0] peak_deferral;
        logic [31:0] enqueued_total;
        logic [31:0] applied_total;
        logic        last;
    } fbcq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_WORDS,
        ST_SUMMARY
    } fbcq_state_t;

endpackage

// ===== rtl/frame_batched_command_queue.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  command word or frame tick (fbcq_in_t)
// m_        out        m_valid / m_ready  word, status or summary (fbcq_out_t)
// cfg_      in         cfg_wr_en          max_actions (2 bits), no wait
// A command word is accepted when s_ready; the final word returns its status in the next cycle.
// A frame tick is accepted in ST_IDLE, then each forwarded command takes a slot memory read
// (ST_SLOT) and one word read per word (ST_WORDS), then the summary is loaded (ST_SUMMARY).
// Reset is synchronous on aresetn low; memory contents are left as they are.
// A stalled m_ready holds the current result, blocks the input and stops word reads.
module frame_batched_command_queue #(
    parameter int QUEUE_DEPTH = fbcq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_WORDS   = fbcq_pkg::MAX_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fbcq_pkg::fbcq_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fbcq_pkg::fbcq_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import fbcq_pkg::*;

    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WCNT_W      = $clog2(MAX_WORDS + 2);
    localparam int LEN_W       = $clog2(MAX_WORDS + 1);
    localparam int STORE_DEPTH = QUEUE_DEPTH * MAX_WORDS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SENT_W      = LEN_W + 32;

    // memories
    logic [31:0]       word_mem [STORE_DEPTH];
    logic [SENT_W-1:0] slot_mem [QUEUE_DEPTH];
    logic [31:0]       word_q;
    logic [SENT_W-1:0] slot_q;

    // control state
    fbcq_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, tail_reg;
    logic [ADDR_W-1:0] head_base_reg, tail_base_reg;
    logic [QCNT_W-1:0] queued_reg, peak_queued_reg;
    logic [WCNT_W-1:0] in_cnt_reg;
    logic              blocked_reg;
    logic [31:0]       frame_reg, peak_wait_reg, accepted_reg, forwarded_reg;
    logic [1:0]        max_actions_reg, applied_reg;
    logic              pend_reg, pend_final_reg, m_valid_reg;

    // payload registers
    logic [LEN_W-1:0]  len_reg, idx_reg;
    fbcq_out_t         m_data_reg, m_data_next;

    // datapath signals
    logic              s_fire, word_fire, tick_fire, out_free, out_load;
    logic              word_issue, is_final, retire, more_first, more_next;
    logic              slot_rd_en, summary_load, full, store_we;
    logic [SLOT_W-1:0] head_inc, tail_inc, slot_rd_addr;
    logic [ADDR_W-1:0] head_base_inc, tail_base_inc, store_waddr, word_raddr;
    logic [WCNT_W-1:0] cnt_new;
    logic              blocked_new, cmd_ok;
    logic [1:0]        st_code;
    logic [31:0]       wait_frames;
    logic [QCNT_W+4:0] peak_ext;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign word_fire = s_fire && (s_data.op == OP_WORD);
    assign tick_fire = s_fire && (s_data.op == OP_TICK);
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = pend_reg && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ring pointers and their word bases
    assign head_inc      = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc      = (tail_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_base_inc = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                         : head_base_reg + ADDR_W'(MAX_WORDS);
    assign tail_base_inc = (tail_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                         : tail_base_reg + ADDR_W'(MAX_WORDS);

    // incoming command assembly
    assign full        = (queued_reg == QCNT_W'(QUEUE_DEPTH));
    assign store_we    = word_fire && !full && (in_cnt_reg < WCNT_W'(MAX_WORDS));
    assign store_waddr = tail_base_reg + ADDR_W'(in_cnt_reg);
    assign cnt_new     = (in_cnt_reg <= WCNT_W'(MAX_WORDS)) ? in_cnt_reg + 1'b1 : in_cnt_reg;
    assign blocked_new = blocked_reg || full;
    assign cmd_ok      = word_fire && s_data.end_of_command && (st_code == STATUS_OK);

    always_comb begin
        priority if (cnt_new > WCNT_W'(MAX_WORDS)) begin
            st_code = STATUS_TOO_LONG;
        end else if (blocked_new) begin
            st_code = STATUS_FULL;
        end else begin
            st_code = STATUS_OK;
        end
    end

    // drain control
    assign is_final    = (idx_reg + 1'b1) == len_reg;
    assign word_raddr  = head_base_reg + ADDR_W'(idx_reg);
    assign more_first  = (max_actions_reg != 2'd0) && (queued_reg != '0);
    assign more_next   = (({1'b0, applied_reg} + 3'd1) < {1'b0, max_actions_reg})
                       && (queued_reg != QCNT_W'(1));
    assign wait_frames = frame_reg - slot_q[31:0];
    assign peak_ext    = {5'd0, peak_queued_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_fire) begin
                    state_next = more_first ? ST_SLOT : ST_SUMMARY;
                end
            end
            ST_SLOT: begin
                state_next = ST_WORDS;
            end
            ST_WORDS: begin
                if (retire) begin
                    state_next = more_next ? ST_SLOT : ST_SUMMARY;
                end
            end
            ST_SUMMARY: begin
                if (summary_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        word_issue   = 1'b0;
        summary_load = 1'b0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = head_reg;
        unique case (state_reg)
            ST_IDLE: begin
                slot_rd_en = tick_fire && more_first;
            end
            ST_WORDS: begin
                word_issue   = !pend_reg || out_load;
                slot_rd_en   = word_issue && is_final && more_next;
                slot_rd_addr = head_inc;
            end
            ST_SUMMARY: begin
                summary_load = !pend_reg && out_free;
            end
            default: begin
            end
        endcase
    end

    assign retire = word_issue && is_final;

    // memory ports
    always_ff @(posedge aclk) begin
        if (store_we) begin
            word_mem[store_waddr] <= s_data.word;
        end
        if (word_issue) begin
            word_q <= word_mem[word_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_ok) begin
            slot_mem[tail_reg] <= {LEN_W'(cnt_new), frame_reg};
        end
        if (slot_rd_en) begin
            slot_q <= slot_mem[slot_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            head_base_reg   <= '0;
            tail_base_reg   <= '0;
            queued_reg      <= '0;
            peak_queued_reg <= '0;
            in_cnt_reg      <= '0;
            blocked_reg     <= 1'b0;
            frame_reg       <= '0;
            peak_wait_reg   <= '0;
            accepted_reg    <= '0;
            forwarded_reg   <= '0;
            max_actions_reg <= 2'd1;
            applied_reg     <= '0;
            pend_reg        <= 1'b0;
            pend_final_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                max_actions_reg <= cfg_wr_data;
            end

            // command assembly; restart after the final word whatever its status
            if (word_fire) begin
                if (s_data.end_of_command) begin
                    in_cnt_reg  <= '0;
                    blocked_reg <= 1'b0;
                end else begin
                    in_cnt_reg  <= cnt_new;
                    blocked_reg <= blocked_new;
                end
            end
            if (cmd_ok) begin
                tail_reg      <= tail_inc;
                tail_base_reg <= tail_base_inc;
                accepted_reg  <= accepted_reg + 1'b1;
                if ((queued_reg + 1'b1) > peak_queued_reg) begin
                    peak_queued_reg <= queued_reg + 1'b1;
                end
            end

            if (tick_fire) begin
                applied_reg <= '0;
            end
            if (state_reg == ST_SLOT && wait_frames > peak_wait_reg) begin
                peak_wait_reg <= wait_frames;
            end
            if (retire) begin
                head_reg      <= head_inc;
                head_base_reg <= head_base_inc;
                applied_reg   <= applied_reg + 1'b1;
                forwarded_reg <= forwarded_reg + 1'b1;
            end
            // enqueue and retire never share a cycle
            if (cmd_ok) begin
                queued_reg <= queued_reg + 1'b1;
            end else if (retire) begin
                queued_reg <= queued_reg - 1'b1;
            end
            if (summary_load) begin
                frame_reg <= frame_reg + 1'b1;
            end

            // read data waiting for the output register
            if (word_issue) begin
                pend_reg       <= 1'b1;
                pend_final_reg <= is_final;
            end else if (out_load) begin
                pend_reg <= 1'b0;
            end

            if ((word_fire && s_data.end_of_command) || out_load || summary_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        priority if (word_fire && s_data.end_of_command) begin
            m_data_next        = '0;
            m_data_next.kind   = KIND_STATUS;
            m_data_next.status = st_code;
            m_data_next.last   = 1'b1;
        end else if (out_load) begin
            m_data_next               = '0;
            m_data_next.kind          = KIND_WORD;
            m_data_next.word_out      = word_q;
            m_data_next.word_is_final = pend_final_reg;
        end else if (summary_load) begin
            m_data_next                = '0;
            m_data_next.kind           = KIND_SUMMARY;
            m_data_next.applied_count  = applied_reg;
            m_data_next.frame_number   = frame_reg + 1'b1;
            m_data_next.peak_occupancy = peak_ext[4:0];
            m_data_next.peak_deferral  = peak_wait_reg;
            m_data_next.enqueued_total = accepted_reg;
            m_data_next.applied_total  = forwarded_reg;
            m_data_next.last           = 1'b1;
        end else begin
            m_data_next = m_data_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SLOT) begin
            len_reg <= slot_q[SENT_W-1:32];
            idx_reg <= '0;
        end else if (word_issue) begin
            idx_reg <= idx_reg + 1'b1;
        end

        m_data_reg <= m_data_next;
    end

endmodule
